// ----- hw/rtl/lfpd_pkg.sv -----
// Package for the line-follow PD and bicycle-model step block.
// Holds the fixed-point constants, the CORDIC angle table, datapath operation codes
// and the controller/datapath interface structs. Depends on nothing.
package lfpd_pkg;

   // CORDIC iteration count, limited by the length of the angle table.
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_N     = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
   localparam int SQRT_N       = 32;
   localparam int DIV_N        = 52;
   localparam int CNT_W        = 6;

   // Fixed-point constants.
   localparam int STEER_STEP   = 20017;
   localparam int STEER_MAX    = 51472;
   localparam int SPEED_STEP   = 6554;
   localparam int SPEED_MAX    = 655360;
   localparam int PD_SCALE     = 457528;
   localparam int TURN_SCALE   = 26076;
   localparam int RAD_TO_BAM32 = 683565276;
   localparam int CORDIC_START = 652032874;
   localparam int DIV20_RECIP  = 838861;

   // Reset values of the configuration registers.
   localparam logic [20:0] TARGET_SPEED_RST = 21'd98304;
   localparam logic [15:0] GAIN_P_RST       = 16'd896;
   localparam logic [15:0] GAIN_D_RST       = 16'd384;

   // Configuration register indexes.
   localparam logic [2:0] REG_TARGET_SPEED  = 3'd0;
   localparam logic [2:0] REG_GAIN_P        = 3'd1;
   localparam logic [2:0] REG_GAIN_D        = 3'd2;
   localparam logic [2:0] REG_START_X       = 3'd3;
   localparam logic [2:0] REG_START_Y       = 3'd4;
   localparam logic [2:0] REG_START_HEADING = 3'd5;

   // Datapath operation codes.
   localparam logic [4:0] OP_NONE     = 5'd0;
   localparam logic [4:0] OP_LOAD     = 5'd1;
   localparam logic [4:0] OP_RESTART  = 5'd2;
   localparam logic [4:0] OP_MUL_P    = 5'd3;
   localparam logic [4:0] OP_MUL_D    = 5'd4;
   localparam logic [4:0] OP_PD_ADD   = 5'd5;
   localparam logic [4:0] OP_MUL_PD   = 5'd6;
   localparam logic [4:0] OP_TGT      = 5'd7;
   localparam logic [4:0] OP_STEER    = 5'd8;
   localparam logic [4:0] OP_SCALE    = 5'd9;
   localparam logic [4:0] OP_ZST      = 5'd10;
   localparam logic [4:0] OP_CORDIC   = 5'd11;
   localparam logic [4:0] OP_HEAD     = 5'd12;
   localparam logic [4:0] OP_MUL_CC   = 5'd13;
   localparam logic [4:0] OP_MUL_SS   = 5'd14;
   localparam logic [4:0] OP_M2       = 5'd15;
   localparam logic [4:0] OP_SQRT     = 5'd16;
   localparam logic [4:0] OP_MUL_ST   = 5'd17;
   localparam logic [4:0] OP_MUL_P1   = 5'd18;
   localparam logic [4:0] OP_DIV_INIT = 5'd19;
   localparam logic [4:0] OP_DIV      = 5'd20;
   localparam logic [4:0] OP_MUL_HC   = 5'd21;
   localparam logic [4:0] OP_UPD_X    = 5'd22;
   localparam logic [4:0] OP_UPD_Y    = 5'd23;
   localparam logic [4:0] OP_OUT      = 5'd24;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic [4:0] op;
      logic [4:0] idx;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic restart;
   } sts_type;

   // CORDIC angle for each iteration, 32-bit binary angle.
   function automatic logic [33:0] atan_val(input logic [4:0] i);
      logic [33:0] v;
      case (i)
         5'd0:  v = 34'h020000000;
         5'd1:  v = 34'h012E4051E;
         5'd2:  v = 34'h009FB385B;
         5'd3:  v = 34'h0051111D4;
         5'd4:  v = 34'h0028B0D43;
         5'd5:  v = 34'h00145D7E1;
         5'd6:  v = 34'h000A2F61E;
         5'd7:  v = 34'h000517C55;
         5'd8:  v = 34'h00028BE53;
         5'd9:  v = 34'h000145F2F;
         5'd10: v = 34'h0000A2F98;
         5'd11: v = 34'h0000517CC;
         5'd12: v = 34'h000028BE6;
         5'd13: v = 34'h0000145F3;
         5'd14: v = 34'h00000A2F9;
         5'd15: v = 34'h00000517D;
         5'd16: v = 34'h0000028BE;
         5'd17: v = 34'h00000145F;
         5'd18: v = 34'h000000A30;
         5'd19: v = 34'h000000518;
         5'd20: v = 34'h00000028C;
         5'd21: v = 34'h000000146;
         5'd22: v = 34'h0000000A3;
         5'd23: v = 34'h000000051;
         default: v = 34'h0;
      endcase
      return v;
   endfunction

endpackage

// ----- hw/rtl/lfpd_ctrl.sv -----
// Controller of the line-follow step block: sequences the datapath operations.
// Depends on lfpd_pkg for operation codes and interface structs.
module lfpd_ctrl import lfpd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_BRANCH   = 5'd1;
   localparam logic [4:0] S_RESTART  = 5'd2;
   localparam logic [4:0] S_MUL_P    = 5'd3;
   localparam logic [4:0] S_MUL_D    = 5'd4;
   localparam logic [4:0] S_PD_ADD   = 5'd5;
   localparam logic [4:0] S_MUL_PD   = 5'd6;
   localparam logic [4:0] S_TGT      = 5'd7;
   localparam logic [4:0] S_STEER    = 5'd8;
   localparam logic [4:0] S_SCALE    = 5'd9;
   localparam logic [4:0] S_ZST      = 5'd10;
   localparam logic [4:0] S_CORD_H   = 5'd11;
   localparam logic [4:0] S_HEAD     = 5'd12;
   localparam logic [4:0] S_CORD_S   = 5'd13;
   localparam logic [4:0] S_MUL_CC   = 5'd14;
   localparam logic [4:0] S_MUL_SS   = 5'd15;
   localparam logic [4:0] S_M2       = 5'd16;
   localparam logic [4:0] S_SQRT     = 5'd17;
   localparam logic [4:0] S_MUL_ST   = 5'd18;
   localparam logic [4:0] S_MUL_P1   = 5'd19;
   localparam logic [4:0] S_DIV_INIT = 5'd20;
   localparam logic [4:0] S_DIV      = 5'd21;
   localparam logic [4:0] S_MUL_HC   = 5'd22;
   localparam logic [4:0] S_UPD_X    = 5'd23;
   localparam logic [4:0] S_UPD_Y    = 5'd24;
   localparam logic [4:0] S_OUT      = 5'd25;

   logic [4:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_ok;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_ok    = !rsp_valid_ff || !rsp_stall;

   // Next state, loop counter and command decode.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = OP_NONE;
      cmd.idx      = cnt_ff[4:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_BRANCH;
            end
         end
         S_BRANCH: state_in = sts.restart ? S_RESTART : S_MUL_P;
         S_RESTART: begin
            cmd.op   = OP_RESTART;
            state_in = S_OUT;
         end
         S_MUL_P: begin
            cmd.op   = OP_MUL_P;
            state_in = S_MUL_D;
         end
         S_MUL_D: begin
            cmd.op   = OP_MUL_D;
            state_in = S_PD_ADD;
         end
         S_PD_ADD: begin
            cmd.op   = OP_PD_ADD;
            state_in = S_MUL_PD;
         end
         S_MUL_PD: begin
            cmd.op   = OP_MUL_PD;
            state_in = S_TGT;
         end
         S_TGT: begin
            cmd.op   = OP_TGT;
            state_in = S_STEER;
         end
         S_STEER: begin
            cmd.op   = OP_STEER;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.op   = OP_SCALE;
            state_in = S_ZST;
         end
         S_ZST: begin
            cmd.op   = OP_ZST;
            cnt_in   = '0;
            state_in = S_CORD_H;
         end
         S_CORD_H: begin
            cmd.op = OP_CORDIC;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CORDIC_N - 1)) begin
               cnt_in   = '0;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            cmd.op   = OP_HEAD;
            state_in = S_CORD_S;
         end
         S_CORD_S: begin
            cmd.op = OP_CORDIC;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CORDIC_N - 1)) begin
               cnt_in   = '0;
               state_in = S_MUL_CC;
            end
         end
         S_MUL_CC: begin
            cmd.op   = OP_MUL_CC;
            state_in = S_MUL_SS;
         end
         S_MUL_SS: begin
            cmd.op   = OP_MUL_SS;
            state_in = S_M2;
         end
         S_M2: begin
            cmd.op   = OP_M2;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = OP_SQRT;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQRT_N - 1)) begin
               cnt_in   = '0;
               state_in = S_MUL_ST;
            end
         end
         S_MUL_ST: begin
            cmd.op   = OP_MUL_ST;
            state_in = S_MUL_P1;
         end
         S_MUL_P1: begin
            cmd.op   = OP_MUL_P1;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_N - 1)) begin
               cnt_in   = '0;
               state_in = S_MUL_HC;
            end
         end
         S_MUL_HC: begin
            cmd.op   = OP_MUL_HC;
            state_in = S_UPD_X;
         end
         S_UPD_X: begin
            cmd.op   = OP_UPD_X;
            state_in = S_UPD_Y;
         end
         S_UPD_Y: begin
            cmd.op   = OP_UPD_Y;
            state_in = S_OUT;
         end
         S_OUT: begin
            // Hand the result over once the output register is free.
            if (out_ok) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hw/rtl/lfpd_dpath.sv -----
// Datapath of the line-follow step block: configuration, vehicle state, shared
// multiplier, CORDIC, square root and divider. Depends on lfpd_pkg.
module lfpd_dpath import lfpd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic signed [14:0] req_line_offset,
   input  logic               req_restart,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output logic signed [16:0] rsp_steer_angle,
   output logic signed [20:0] rsp_speed_now,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic [15:0]        rsp_heading
);

   // Configuration registers.
   logic signed [20:0] tspeed_ff;
   logic [15:0]        gain_p_ff, gain_d_ff, start_hd_ff;
   logic [31:0]        start_x_ff, start_y_ff;

   // Vehicle state.
   logic signed [14:0] prev_ff;
   logic signed [20:0] speed_ff;
   logic signed [16:0] steer_ff;
   logic [31:0]        x_ff, y_ff;
   logic [15:0]        hd_ff;

   // Working registers.
   logic signed [14:0] off_ff;
   logic               rst_ff;
   logic signed [69:0] prod_ff;
   logic signed [34:0] pd_ff;
   logic signed [31:0] tgt_ff;
   logic signed [17:0] s_ff;
   logic signed [33:0] zst_ff, cx_ff, cy_ff, cz_ff, hc_ff, hs_ff, ss_ff;
   logic               flip_ff;
   logic [32:0]        su_ff;
   logic [63:0]        m2_ff, sv_ff, sr_ff, sb_ff;
   logic [32:0]        m_ff, rem_ff;
   logic [51:0]        dn_ff;
   logic [15:0]        q_ff;
   logic               neg_ff;

   // Shared multiplier.
   logic signed [34:0] ma, mb;
   logic signed [69:0] mul;

   logic signed [15:0] diff;
   logic signed [22:0] ts_w, sp_w, sp_n;
   logic signed [33:0] tg_w, st_w, st_n;
   logic [20:0]        speed_mag;
   logic [69:0]        prod_mag;
   logic               prod_neg;
   logic [31:0]        tgt_q, zst_q;
   logic [16:0]        s_q;
   logic [31:0]        head_a;
   logic               head_flip;
   logic signed [33:0] cx_n, cy_n, cz_n;
   logic [32:0]        cx_mag, cy_mag;
   logic [63:0]        sq_t;
   logic [33:0]        rem2;
   logic [15:0]        turn;
   logic signed [69:0] pos_r;

   assign sts.restart = rst_ff;

   assign diff      = 16'(off_ff) - 16'(prev_ff);
   assign speed_mag = speed_ff[20] ? 21'(-speed_ff) : 21'(speed_ff);
   assign prod_neg  = prod_ff[69];
   assign prod_mag  = prod_neg ? 70'(-prod_ff) : 70'(prod_ff);
   assign cx_mag    = cx_ff[33] ? 33'(-cx_ff) : 33'(cx_ff);
   assign cy_mag    = cy_ff[33] ? 33'(-cy_ff) : 33'(cy_ff);

   // Operand selection for the shared multiplier.
   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.op)
         OP_MUL_P: begin
            ma = {19'd0, gain_p_ff};
            mb = 35'(off_ff);
         end
         OP_MUL_D: begin
            ma = {19'd0, gain_d_ff};
            mb = 35'(diff);
         end
         OP_MUL_PD: begin
            ma = pd_ff;
            mb = 35'(PD_SCALE);
         end
         OP_STEER: begin
            ma = {13'd0, 22'(speed_mag) + 22'd10};
            mb = 35'(DIV20_RECIP);
         end
         OP_SCALE: begin
            ma = 35'(steer_ff);
            mb = 35'(RAD_TO_BAM32);
         end
         OP_MUL_CC: begin
            ma = {2'b00, cx_mag};
            mb = {2'b00, cx_mag};
         end
         OP_MUL_SS: begin
            ma = {2'b00, su_ff};
            mb = {2'b00, su_ff};
         end
         OP_MUL_ST: begin
            ma = 35'(s_ff);
            mb = 35'(TURN_SCALE);
         end
         OP_MUL_P1: begin
            ma = 35'(signed'(prod_ff[32:0]));
            mb = 35'(ss_ff);
         end
         OP_MUL_HC: begin
            ma = 35'(s_ff);
            mb = 35'(hc_ff);
         end
         OP_UPD_X: begin
            ma = 35'(s_ff);
            mb = 35'(hs_ff);
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   assign mul = ma * mb;

   // Speed slew toward the target and clamp.
   always_comb begin
      ts_w = 23'(tspeed_ff);
      sp_w = 23'(speed_ff);
      if (ts_w > sp_w) begin
         sp_n = sp_w + 23'(SPEED_STEP);
         if (sp_n > ts_w) sp_n = ts_w;
      end else begin
         sp_n = sp_w - 23'(SPEED_STEP);
         if (sp_n < ts_w) sp_n = ts_w;
      end
      if (sp_n > 23'(SPEED_MAX)) sp_n = 23'(SPEED_MAX);
      else if (sp_n < -23'(SPEED_MAX)) sp_n = -23'(SPEED_MAX);
   end

   // Steer slew toward the PD target and clamp.
   always_comb begin
      tg_w = 34'(tgt_ff);
      st_w = 34'(steer_ff);
      if (tg_w > st_w) begin
         st_n = st_w + 34'(STEER_STEP);
         if (st_n > tg_w) st_n = tg_w;
      end else begin
         st_n = st_w - 34'(STEER_STEP);
         if (st_n < tg_w) st_n = tg_w;
      end
      if (st_n > 34'(STEER_MAX)) st_n = 34'(STEER_MAX);
      else if (st_n < -34'(STEER_MAX)) st_n = -34'(STEER_MAX);
   end

   // Scalings of the product register; all but s_q are rounded.
   assign tgt_q = 32'((prod_mag + 70'd8388608) >> 24);
   assign s_q   = 17'(prod_ff >>> 24);
   assign zst_q = 32'((prod_mag + 70'd32768) >> 16);
   assign pos_r = (prod_ff + 70'sd536870912) >>> 30;

   // Heading folded into the right half plane for the CORDIC.
   assign head_a    = {hd_ff, 16'h0000};
   assign head_flip = head_a[31] ^ head_a[30];

   // One CORDIC rotation step.
   always_comb begin
      if (!cz_ff[33]) begin
         cx_n = cx_ff - (cy_ff >>> cmd.idx);
         cy_n = cy_ff + (cx_ff >>> cmd.idx);
         cz_n = cz_ff - signed'(atan_val(cmd.idx));
      end else begin
         cx_n = cx_ff + (cy_ff >>> cmd.idx);
         cy_n = cy_ff - (cx_ff >>> cmd.idx);
         cz_n = cz_ff + signed'(atan_val(cmd.idx));
      end
   end

   assign sq_t = sr_ff + sb_ff;
   assign rem2 = {rem_ff, dn_ff[51]};
   assign turn = (m_ff == '0) ? 16'd0 : (neg_ff ? 16'(-q_ff) : q_ff);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         tspeed_ff   <= TARGET_SPEED_RST;
         gain_p_ff   <= GAIN_P_RST;
         gain_d_ff   <= GAIN_D_RST;
         start_x_ff  <= '0;
         start_y_ff  <= '0;
         start_hd_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_TARGET_SPEED:  tspeed_ff   <= csr_wdata[20:0];
            REG_GAIN_P:        gain_p_ff   <= csr_wdata[15:0];
            REG_GAIN_D:        gain_d_ff   <= csr_wdata[15:0];
            REG_START_X:       start_x_ff  <= csr_wdata;
            REG_START_Y:       start_y_ff  <= csr_wdata;
            REG_START_HEADING: start_hd_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Vehicle state.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         speed_ff <= '0;
         steer_ff <= '0;
         x_ff     <= '0;
         y_ff     <= '0;
         hd_ff    <= '0;
         rst_ff   <= 1'b0;
      end else begin
         case (cmd.op)
            OP_LOAD: rst_ff <= req_restart;
            OP_RESTART: begin
               prev_ff  <= '0;
               speed_ff <= '0;
               steer_ff <= '0;
               x_ff     <= start_x_ff;
               y_ff     <= start_y_ff;
               hd_ff    <= start_hd_ff;
            end
            OP_TGT: begin
               prev_ff  <= off_ff;
               speed_ff <= sp_n[20:0];
            end
            OP_STEER:  steer_ff <= st_n[16:0];
            OP_MUL_HC: hd_ff    <= hd_ff + turn;
            OP_UPD_X:  x_ff     <= x_ff + pos_r[31:0];
            OP_UPD_Y:  y_ff     <= y_ff + pos_r[31:0];
            default: ;
         endcase
      end
   end

   // Working registers of the step computation.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: off_ff <= req_line_offset;
         OP_MUL_P: prod_ff <= mul;
         OP_MUL_D: begin
            pd_ff   <= 35'(prod_ff);
            prod_ff <= mul;
         end
         OP_PD_ADD: pd_ff <= pd_ff + 35'(prod_ff);
         OP_MUL_PD: prod_ff <= mul;
         OP_TGT: tgt_ff <= prod_neg ? signed'(tgt_q) : -signed'(tgt_q);
         OP_STEER: prod_ff <= mul;
         OP_SCALE: begin
            s_ff    <= speed_ff[20] ? -18'(s_q) : 18'(s_q);
            prod_ff <= mul;
         end
         OP_ZST: begin
            zst_ff  <= prod_neg ? -34'(zst_q) : 34'(zst_q);
            flip_ff <= head_flip;
            cx_ff   <= 34'(CORDIC_START);
            cy_ff   <= '0;
            cz_ff   <= 34'(signed'(head_flip ? (head_a ^ 32'h8000_0000) : head_a));
         end
         OP_CORDIC: begin
            cx_ff <= cx_n;
            cy_ff <= cy_n;
            cz_ff <= cz_n;
         end
         OP_HEAD: begin
            hc_ff <= flip_ff ? -cx_ff : cx_ff;
            hs_ff <= flip_ff ? -cy_ff : cy_ff;
            cx_ff <= 34'(CORDIC_START);
            cy_ff <= '0;
            cz_ff <= zst_ff;
         end
         OP_MUL_CC: begin
            su_ff   <= cy_mag;
            ss_ff   <= cy_ff;
            prod_ff <= mul;
         end
         OP_MUL_SS: begin
            m2_ff   <= prod_ff[63:0];
            prod_ff <= mul;
         end
         OP_M2: begin
            sv_ff <= m2_ff + prod_ff[65:2];
            sr_ff <= '0;
            sb_ff <= 64'h4000_0000_0000_0000;
         end
         OP_SQRT: begin
            // Bit-serial square root: each step decides one result bit.
            if (sv_ff >= sq_t) begin
               sv_ff <= sv_ff - sq_t;
               sr_ff <= (sr_ff >> 1) + sb_ff;
            end else begin
               sr_ff <= sr_ff >> 1;
            end
            sb_ff <= sb_ff >> 2;
         end
         OP_MUL_ST: begin
            m_ff    <= sr_ff[32:0];
            prod_ff <= mul;
         end
         OP_MUL_P1: prod_ff <= mul;
         OP_DIV_INIT: begin
            neg_ff <= prod_neg;
            dn_ff  <= 52'((prod_mag + {22'd0, m_ff, 15'd0}) >> 16);
            rem_ff <= '0;
            q_ff   <= '0;
         end
         OP_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (rem2 >= {1'b0, m_ff}) begin
               rem_ff <= 33'(rem2 - {1'b0, m_ff});
               q_ff   <= {q_ff[14:0], 1'b1};
            end else begin
               rem_ff <= rem2[32:0];
               q_ff   <= {q_ff[14:0], 1'b0};
            end
            dn_ff <= dn_ff << 1;
         end
         OP_MUL_HC: prod_ff <= mul;
         OP_UPD_X:  prod_ff <= mul;
         OP_OUT: begin
            rsp_steer_angle <= steer_ff;
            rsp_speed_now   <= speed_ff;
            rsp_pos_x       <= x_ff;
            rsp_pos_y       <= y_ff;
            rsp_heading     <= hd_ff;
         end
         default: ;
      endcase
   end

endmodule

// ----- hw/rtl/line_follow_pd_bicycle_step.sv -----
// Top level of the line-follow PD and bicycle-model step block.
// Depends on lfpd_pkg, lfpd_ctrl and lfpd_dpath.
//
// One request is one 50 ms control tick. The processing time of a normal request is set
// by one shared multiplier and three bit-serial units run in turn: two 16-step CORDIC
// passes, a 32-step square root and a 52-step restoring divide; a restart request skips
// them all. Requests are worked one at a time; the next request is taken as soon as the
// response is in the output register, even while that response is still stalled.
// Configuration is written through the csr port; the user must write it only while the
// block is idle, as the block itself does not enforce this.
module line_follow_pd_bicycle_step import lfpd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [14:0] req_line_offset,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [16:0] rsp_steer_angle,
   output logic signed [20:0] rsp_speed_now,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic [15:0]        rsp_heading,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   // Sequencer.
   lfpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Arithmetic and state.
   lfpd_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_line_offset (req_line_offset),
      .req_restart     (req_restart),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_steer_angle (rsp_steer_angle),
      .rsp_speed_now   (rsp_speed_now),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_heading     (rsp_heading)
   );

endmodule

// ----- sim/line_follow_pd_bicycle_step_test.sv -----
// Self-checking testbench for the line-follow PD and bicycle-model step block.
// Depends on lfpd_pkg and line_follow_pd_bicycle_step; a built-in predictor gives the
// expected steer, speed and pose for every accepted request.
`timescale 1ns / 1ps

module line_follow_pd_bicycle_step_test import lfpd_pkg::*; ();

   localparam int LATENCY = 136;
   localparam int SETTLE = LATENCY + 20;

   typedef struct {
      logic signed [14:0] offset;
      logic               restart;
   } tick_type;

   typedef struct {
      logic signed [16:0] steer;
      logic signed [20:0] speed;
      logic [31:0]        x;
      logic [31:0]        y;
      logic [15:0]        heading;
   } pose_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_restart = 0, rsp_stall = 0, csr_wr_en = 0;
   logic signed [14:0] req_line_offset = 0;
   logic [2:0] csr_index = REG_TARGET_SPEED;
   logic [31:0] csr_wdata = 0;
   logic req_stall, rsp_valid;
   logic signed [16:0] rsp_steer_angle;
   logic signed [20:0] rsp_speed_now;
   logic signed [31:0] rsp_pos_x, rsp_pos_y;
   logic [15:0] rsp_heading;

   line_follow_pd_bicycle_step DUT (.*);

   // Predictor state and its copy of the configuration registers.
   longint cfg_speed = 98304, cfg_kp = 896, cfg_kd = 384;
   logic [31:0] cfg_x0 = 0, cfg_y0 = 0;
   logic [15:0] cfg_h0 = 0;
   longint car_prev = 0, car_speed = 0, car_steer = 0;
   logic [31:0] car_x = 0, car_y = 0;
   logic [15:0] car_heading = 0;

   tick_type pending_ticks[$];
   pose_type expected_poses[$];
   int errors = 0, sent = 0, restarts = 0, checked = 0;
   bit idle_on = 1;
   int hold_cycles = 0;
   int drv_gap = 0, rcv_gap = 0;

   initial forever #2 clock = ~clock;

   // Rounded division of magnitudes with the sign applied afterwards.
   function automatic longint div_rnd(longint num, longint unsigned den);
      longint unsigned mag;
      if (den == 0) return 0;
      mag = num < 0 ? -num : num;
      mag = (mag + den / 2) / den;
      return num < 0 ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Rotation-mode CORDIC on a signed 32-bit binary angle; results in Q30.
   function automatic void rotate(longint z, output longint c, output longint s);
      longint x = CORDIC_START, y = 0, nx;
      for (int i = 0; i < CORDIC_N; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(atan_val(i[4:0]));
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(atan_val(i[4:0]));
         end
         x = nx;
      end
      c = x;
      s = y;
   endfunction

   // Advances the car by one tick and returns the pose the block must report.
   function automatic pose_type advance_car(tick_type t);
      pose_type p;
      longint off, pd, tgt, step, hc, hs, sc, ss, turn, z;
      longint unsigned cu, su, mag;
      logic [31:0] a;
      bit flip;
      if (t.restart) begin
         car_prev = 0;
         car_speed = 0;
         car_steer = 0;
         car_x = cfg_x0;
         car_y = cfg_y0;
         car_heading = cfg_h0;
      end else begin
         off = t.offset;
         pd = cfg_kp * off + cfg_kd * (off - car_prev);
         tgt = -div_rnd(pd * PD_SCALE, 64'd1 << 24);
         car_prev = off;
         // Speed and steer slew toward their targets, then clamp.
         if (cfg_speed > car_speed) begin
            car_speed += SPEED_STEP;
            if (car_speed > cfg_speed) car_speed = cfg_speed;
         end else begin
            car_speed -= SPEED_STEP;
            if (car_speed < cfg_speed) car_speed = cfg_speed;
         end
         if (car_speed > SPEED_MAX) car_speed = SPEED_MAX;
         else if (car_speed < -SPEED_MAX) car_speed = -SPEED_MAX;
         if (tgt > car_steer) begin
            car_steer += STEER_STEP;
            if (car_steer > tgt) car_steer = tgt;
         end else begin
            car_steer -= STEER_STEP;
            if (car_steer < tgt) car_steer = tgt;
         end
         if (car_steer > STEER_MAX) car_steer = STEER_MAX;
         else if (car_steer < -STEER_MAX) car_steer = -STEER_MAX;
         step = div_rnd(car_speed, 20);
         // Fold the heading into the right half plane for the CORDIC.
         a = {car_heading, 16'h0};
         flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
         if (flip) a[31] = ~a[31];
         z = longint'(signed'(a));
         rotate(z, hc, hs);
         if (flip) begin
            hc = -hc;
            hs = -hs;
         end
         rotate(div_rnd(car_steer * RAD_TO_BAM32, 65536), sc, ss);
         cu = sc < 0 ? -sc : sc;
         su = ss < 0 ? -ss : ss;
         mag = int_sqrt(cu * cu + (su * su) / 4);
         turn = div_rnd(step * ss * TURN_SCALE, mag << 16);
         car_x += 32'((step * hc + (64'sd1 <<< 29)) >>> 30);
         car_y += 32'((step * hs + (64'sd1 <<< 29)) >>> 30);
         car_heading = car_heading + 16'(turn);
      end
      p.steer = 17'(car_steer);
      p.speed = 21'(car_speed);
      p.x = car_x;
      p.y = car_y;
      p.heading = car_heading;
      return p;
   endfunction

   task automatic report(string what, longint got, longint want);
      errors++;
      $display("MISMATCH response %0d %s: got %0d expected %0d", checked, what, got, want);
   endtask

   // Request driver: takes requests from the pending queue, with random gaps.
   always @(posedge clock) begin
      tick_type t;
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            t.offset = req_line_offset;
            t.restart = req_restart;
            expected_poses.push_back(advance_car(t));
            sent++;
            restarts += t.restart;
         end
         if (!(req_valid && req_stall)) begin
            if (drv_gap > 0) begin
               drv_gap <= drv_gap - 1;
               req_valid <= 0;
            end else if (pending_ticks.size() > 0) begin
               t = pending_ticks.pop_front();
               req_line_offset <= t.offset;
               req_restart <= t.restart;
               req_valid <= 1;
               if (idle_on && $urandom_range(7) == 0) drv_gap <= $urandom_range(1, 16);
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // Response monitor: stalls in bursts or for a long hold, checks each response.
   always @(posedge clock) begin
      pose_type p;
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_poses.size() == 0) begin
               report("unexpected response", 0, 0);
            end else begin
               p = expected_poses.pop_front();
               if (rsp_steer_angle !== p.steer) report("steer", rsp_steer_angle, p.steer);
               if (rsp_speed_now !== p.speed) report("speed", rsp_speed_now, p.speed);
               if (rsp_pos_x !== p.x) report("pos_x", rsp_pos_x, signed'(p.x));
               if (rsp_pos_y !== p.y) report("pos_y", rsp_pos_y, signed'(p.y));
               if (rsp_heading !== p.heading) report("heading", rsp_heading, p.heading);
            end
            checked++;
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall <= 1;
         end else if (rcv_gap > 0) begin
            rcv_gap <= rcv_gap - 1;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
            if (idle_on && $urandom_range(7) == 0) rcv_gap <= $urandom_range(1, 16);
         end
      end
   end

   // Writes one register and mirrors it into the predictor.
   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_TARGET_SPEED:  cfg_speed = longint'(signed'(value[20:0]));
         REG_GAIN_P:        cfg_kp = value[15:0];
         REG_GAIN_D:        cfg_kd = value[15:0];
         REG_START_X:       cfg_x0 = value;
         REG_START_Y:       cfg_y0 = value;
         REG_START_HEADING: cfg_h0 = value[15:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   task automatic drain();
      while (pending_ticks.size() != 0 || expected_poses.size() != 0 || req_valid)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic add_tick(int offset, bit restart);
      tick_type t;
      t.offset = 15'(offset);
      t.restart = restart;
      pending_ticks.push_back(t);
   endtask

   // Mostly a run of in-range offsets, sometimes the full field, rarely a restart.
   task automatic add_random(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(24) == 0) add_tick($urandom, 1);
         else if ($urandom_range(9) == 0) add_tick($urandom, 0);
         else add_tick(int'($urandom_range(19662)) - 9831, 0);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      // Directed: zero steer straight line, then field extremes and restart.
      for (int i = 0; i < 4; i++) add_tick(0, 0);
      add_tick(9831, 0);
      add_tick(-9831, 0);
      add_tick(16383, 0);
      add_tick(-16384, 0);
      add_tick(9831, 1);
      add_tick(-9831, 0);
      add_tick(9831, 0);
      add_tick(-1, 0);
      add_tick(1, 0);
      drain();

      // Phases of random configuration, extremes included.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: write_reg(REG_TARGET_SPEED, 32'(655360));
            1: write_reg(REG_TARGET_SPEED, 32'(-655360));
            2: write_reg(REG_TARGET_SPEED, 32'(1048575));
            3: write_reg(REG_TARGET_SPEED, 32'(-1048576));
            default: write_reg(REG_TARGET_SPEED, 32'(int'($urandom_range(1310720)) - 655360));
         endcase
         write_reg(REG_GAIN_P, ph == 1 ? 0 : ph == 2 ? 16'hFFFF : $urandom_range(4095));
         write_reg(REG_GAIN_D, ph == 1 ? 16'hFFFF : ph == 2 ? 0 : $urandom_range(4095));
         write_reg(REG_START_X, ph == 0 ? 32'h7FFF_FFF0 : ph == 1 ? 32'h8000_0000 : $urandom);
         write_reg(REG_START_Y, ph == 0 ? 32'h8000_0010 : ph == 1 ? 32'hFFFF_FFFF : $urandom);
         write_reg(REG_START_HEADING, ph == 0 ? 16'hFFFF : ph == 1 ? 16'h0000 : $urandom);
         idle_on = (ph < 6);
         add_tick(0, 1);
         if (ph == 3) begin
            // Long receiver hold while requests keep coming.
            hold_cycles = 600;
            add_random(100);
            drain();
            add_random(100);
         end else begin
            add_random(100);
            while (pending_ticks.size() != 0 || expected_poses.size() != 0 || req_valid)
               @(posedge clock);
            add_random(100);
         end
         drain();
      end

      $display("Covered %0d ticks (%0d restarts) over nine register settings.", sent, restarts);
      if (errors == 0)
         $display("line_follow_pd_bicycle_step verification clean");
      else
         $display("line_follow_pd_bicycle_step verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Timed out with %0d responses still expected.", expected_poses.size());
      $display("line_follow_pd_bicycle_step verification failed");
      $finish;
   end

endmodule
